### hdl/mkdlp_pkg.sv
// Shared types and constants for the multi-key debounce / long-press core.
// Used by every module in hdl/; depends on nothing.
package mkdlp_pkg;

    localparam int NUM_KEYS  = 6;
    localparam int PIN_COUNT = 6;
    localparam int DEB_W     = 8;
    localparam int HOLD_W    = 16;
    localparam int EV_W      = 5;
    localparam int OP_W      = 2;
    localparam int KEY_IDX_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 16;
    localparam int REM_CNT_W = $clog2(HOLD_W);

    localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

    // operation codes
    localparam logic [OP_W-1:0] OP_SCAN = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 2'd3;

    // event bits
    localparam logic [EV_W-1:0] EV_PRESS      = 5'b00001;
    localparam logic [EV_W-1:0] EV_SHORT_REL  = 5'b00010;
    localparam logic [EV_W-1:0] EV_LONG_PRESS = 5'b00100;
    localparam logic [EV_W-1:0] EV_LONG_REL   = 5'b01000;
    localparam logic [EV_W-1:0] EV_HOLD       = 5'b10000;

    localparam logic [DEB_W-1:0]  DEB_RESET    = 8'd2;
    localparam logic [HOLD_W-1:0] LONG_RESET   = 16'd100;
    localparam logic [HOLD_W-1:0] ALT_RESET    = 16'd300;
    localparam logic [HOLD_W-1:0] PERIOD_RESET = 16'd20;

    typedef struct packed {
        logic scan_en;
        logic clear_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic stable_next;
        logic hold_restart;
        logic hold_inc;
    } lane_stat_t;

endpackage

### hdl/mkdlp_lane.sv
// One key lane: debounce counter, stable state, hold count and event latch.
// Depends on mkdlp_pkg.
module mkdlp_lane import mkdlp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  lane_ctrl_t        ctrl,
    input  logic              pin_down,
    input  logic              has_long,
    input  logic              has_hold,
    input  logic              hold_hit,
    input  logic [DEB_W-1:0]  debounce_cnt,
    input  logic [HOLD_W-1:0] long_thr,
    output lane_stat_t        stat,
    output logic [EV_W-1:0]   pending,
    output logic [HOLD_W-1:0] hold_count
);

    logic              stable_reg, stable_next;
    logic [DEB_W-1:0]  cnt_reg, cnt_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              long_rep_reg, long_rep_next;
    logic [EV_W-1:0]   pend_reg, pend_next;

    logic              differ, commit, stable_scan, long_base, long_scan, inc;
    logic [DEB_W-1:0]  cnt_inc, cnt_scan;
    logic [HOLD_W-1:0] hold_base, hold_scan;
    logic [EV_W-1:0]   rel_ev, pend_scan;

    always_comb begin
        differ      = pin_down != stable_reg;
        cnt_inc     = (cnt_reg < debounce_cnt) ? cnt_reg + 1'b1 : cnt_reg;
        commit      = differ && (cnt_inc >= debounce_cnt);
        stable_scan = commit ? pin_down : stable_reg;
        cnt_scan    = (differ && !commit) ? cnt_inc : '0;
        rel_ev      = (has_long && long_rep_reg) ? EV_LONG_REL : EV_SHORT_REL;
        pend_scan   = pend_reg | (commit ? (pin_down ? EV_PRESS : rel_ev) : '0);
        // a committed change restarts the hold run
        hold_base   = commit ? '0 : hold_reg;
        long_base   = commit ? 1'b0 : long_rep_reg;
        inc         = stable_scan && (hold_base != HOLD_MAX);
        hold_scan   = inc ? hold_base + 1'b1 : hold_base;
        long_scan   = long_base;
        if (stable_scan) begin
            if (has_long && !long_base && (hold_scan >= long_thr)) begin
                long_scan = 1'b1;
                pend_scan = pend_scan | EV_LONG_PRESS;
            end else if (has_hold && long_base && hold_hit) begin
                pend_scan = pend_scan | EV_HOLD;
            end
        end

        stable_next   = stable_reg;
        cnt_next      = cnt_reg;
        hold_next     = hold_reg;
        long_rep_next = long_rep_reg;
        pend_next     = pend_reg;
        if (ctrl.scan_en) begin
            stable_next   = stable_scan;
            cnt_next      = cnt_scan;
            hold_next     = hold_scan;
            long_rep_next = long_scan;
            pend_next     = pend_scan;
        end else if (ctrl.clear_en) begin
            pend_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg   <= 1'b0;
            cnt_reg      <= '0;
            hold_reg     <= '0;
            long_rep_reg <= 1'b0;
            pend_reg     <= '0;
        end else begin
            stable_reg   <= stable_next;
            cnt_reg      <= cnt_next;
            hold_reg     <= hold_next;
            long_rep_reg <= long_rep_next;
            pend_reg     <= pend_next;
        end
    end

    assign stat.stable_next  = stable_next;
    assign stat.hold_restart = commit;
    assign stat.hold_inc     = inc;
    assign pending           = pend_reg;
    assign hold_count        = hold_reg;

endmodule

### hdl/mkdlp_phase.sv
// Repeat-phase tracker for key 0: keeps hold_count mod period incrementally and
// rebuilds it with a bit-serial remainder after a period write. Depends on mkdlp_pkg.
module mkdlp_phase import mkdlp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              scan_en,
    input  logic [HOLD_W-1:0] period,
    input  logic [HOLD_W-1:0] hold_count,
    input  lane_stat_t        key_stat,
    output logic              hit,
    output logic              busy
);

    logic [HOLD_W-1:0]    phase_reg;
    logic [HOLD_W-1:0]    rem_reg;
    logic [HOLD_W-1:0]    dvd_reg;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    logic [HOLD_W-1:0] base, base_inc, step, rem_step;
    logic [HOLD_W:0]   trial, diff;

    always_comb begin
        base     = key_stat.hold_restart ? '0 : phase_reg;
        base_inc = base + 1'b1;
        step     = key_stat.hold_inc ? ((base_inc == period) ? '0 : base_inc) : base;
        hit      = (period != '0) && (step == '0);
        // one restoring step: shift in the next dividend bit, subtract if it fits
        trial    = {rem_reg, dvd_reg[HOLD_W-1]};
        diff     = trial - {1'b0, period};
        rem_step = (trial >= {1'b0, period}) ? diff[HOLD_W-1:0] : trial[HOLD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvd_reg  <= hold_count;
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[HOLD_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(HOLD_W - 1)) begin
                busy_reg  <= 1'b0;
                phase_reg <= rem_step;
            end
        end else if (scan_en) begin
            phase_reg <= step;
        end
    end

    assign busy = busy_reg;

endmodule

### hdl/mkdlp_merge.sv
// Merge stage: picks the addressed key's pending events for a read or peek and
// gathers the stable states of all lanes into the pressed mask. Depends on mkdlp_pkg.
module mkdlp_merge import mkdlp_pkg::*; (
    input  logic [OP_W-1:0]      op,
    input  logic [KEY_IDX_W-1:0] key_idx,
    input  lane_stat_t           stat [NUM_KEYS],
    input  logic [EV_W-1:0]      pending [NUM_KEYS],
    output logic [EV_W-1:0]      events,
    output logic [PIN_COUNT-1:0] pressed_mask
);

    logic [EV_W-1:0] sel;

    always_comb begin
        sel = '0;
        // an index past the last key matches no lane and reads as no events
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (key_idx == KEY_IDX_W'(i)) begin
                sel = pending[i];
            end
        end
        case (op)
            OP_READ, OP_PEEK: events = sel;
            default:          events = '0;
        endcase
        pressed_mask = '0;
        for (int b = 0; b < PIN_COUNT; b++) begin
            if (b < NUM_KEYS) begin
                pressed_mask[b] = stat[b].stable_next;
            end
        end
    end

endmodule

### hdl/multi_key_debounce_long_press_core.sv
// Top level of the multi-key debounce / long-press core: lanes, phase tracker,
// merge stage, configuration registers and stream handshake. Depends on mkdlp_pkg.
//
// Each input word is first registered; once the output register is free or
// m_tready is high, the key lanes act on it side by side and the result is
// registered. A new word is taken in only after the held one has executed; a
// finished result may wait on m_tready while the next word is taken in. Writing
// hold_repeat_period starts a bit-serial remainder that realigns key 0's repeat
// phase, and s_tready stays low while it runs. s_tuser carries operation (bits 1:0)
// and key_index (bits 4:2); s_tdata carries key_levels (bits 5:0, low = pressed).
module multi_key_debounce_long_press_core import mkdlp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // key_levels[5:0]
    input  logic [7:0]           s_tuser,   // operation[1:0], key_index[4:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata    // events[4:0], pressed_mask[10:5]
);

    logic [DEB_W-1:0]  deb_reg;
    logic [HOLD_W-1:0] long_reg, alt_reg, period_reg;

    logic                 in_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic [PIN_COUNT-1:0] levels_reg;
    logic [KEY_IDX_W-1:0] idx_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic                 exec, phase_busy, phase_hit, period_load;
    lane_stat_t           stat [NUM_KEYS];
    logic [EV_W-1:0]      pending [NUM_KEYS];
    logic [HOLD_W-1:0]    hold_count [NUM_KEYS];
    logic [EV_W-1:0]      events;
    logic [PIN_COUNT-1:0] pressed_mask;

    assign exec        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !in_valid_reg && !phase_busy;
    assign period_load = cfg_we && (cfg_addr == REG_HOLD_PERIOD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg    <= DEB_RESET;
            long_reg   <= LONG_RESET;
            alt_reg    <= ALT_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEBOUNCE:    deb_reg    <= cfg_wdata[DEB_W-1:0];
                REG_LONG_TICKS:  long_reg   <= cfg_wdata[HOLD_W-1:0];
                REG_ALT_TICKS:   alt_reg    <= cfg_wdata[HOLD_W-1:0];
                REG_HOLD_PERIOD: period_reg <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the word until the lanes have processed it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (exec) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser[OP_W-1:0];
            idx_reg    <= s_tuser[OP_W +: KEY_IDX_W];
            levels_reg <= s_tdata[PIN_COUNT-1:0];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_KEYS; gi++) begin : g_lane
            lane_ctrl_t        ctrl;
            logic              raw;
            logic [HOLD_W-1:0] thr;

            assign ctrl.scan_en  = exec && (op_reg == OP_SCAN);
            assign ctrl.clear_en = exec && (op_reg == OP_READ) &&
                                   (idx_reg == KEY_IDX_W'(gi));
            assign thr           = (gi == 2) ? alt_reg : long_reg;

            if (gi < PIN_COUNT) begin : g_pin
                assign raw = !levels_reg[gi];
            end else begin : g_nopin
                assign raw = 1'b0;
            end

            mkdlp_lane u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl),
                .pin_down     (raw),
                .has_long     ((gi == 0) || (gi == 2)),
                .has_hold     (gi == 0),
                .hold_hit     ((gi == 0) ? phase_hit : 1'b0),
                .debounce_cnt (deb_reg),
                .long_thr     (thr),
                .stat         (stat[gi]),
                .pending      (pending[gi]),
                .hold_count   (hold_count[gi])
            );
        end
    endgenerate

    mkdlp_phase u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (period_load),
        .scan_en    (exec && (op_reg == OP_SCAN)),
        .period     (period_reg),
        .hold_count (hold_count[0]),
        .key_stat   (stat[0]),
        .hit        (phase_hit),
        .busy       (phase_busy)
    );

    mkdlp_merge u_merge (
        .op           (op_reg),
        .key_idx      (idx_reg),
        .stat         (stat),
        .pending      (pending),
        .events       (events),
        .pressed_mask (pressed_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_data_reg <= {5'b0, pressed_mask, events};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
